### sv/yfd_pkg.sv
// Package for the YUYV frame decimator: field widths, register indexes,
// reset values and dimension limits.
// Used by yfd_div.sv and yuyv_frame_decimator.sv; depends on nothing.
package yfd_pkg;

  // Dimension registers and derived skips are 13 bits wide.
  localparam int unsigned DimW    = 13;
  // Largest dimension that a register can hold after saturation.
  localparam int unsigned MaxDim  = 4096;
  // Counter width for the iterative divider (counts DimW down to zero).
  localparam int unsigned DivCntW = $clog2(DimW + 1);

  // Configuration port.
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] RegCameraWidth   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCameraHeight  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegPreviewWidth  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegPreviewHeight = 3'd3;

  // Register reset values and the skips they imply.
  localparam logic [DimW-1:0] CameraWidthReset   = 13'd640;
  localparam logic [DimW-1:0] CameraHeightReset  = 13'd480;
  localparam logic [DimW-1:0] PreviewWidthReset  = 13'd320;
  localparam logic [DimW-1:0] PreviewHeightReset = 13'd240;
  localparam logic [DimW-1:0] HorizSkipReset     = 13'd2;
  localparam logic [DimW-1:0] VertSkipReset      = 13'd1 + 13'd1;

  // Stream payload widths.
  localparam int unsigned PixW    = 32;
  localparam int unsigned RowW    = 12;
  localparam int unsigned ColW    = 11;
  localparam int unsigned OutDataW = 56;

endpackage

### sv/yfd_div.sv
// Iterative restoring divider for the decimator's skip factors,
// one quotient bit per clock.
// Depends on yfd_pkg.
module yfd_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [yfd_pkg::DimW-1:0] dividend_i,
  input  logic [yfd_pkg::DimW-1:0] divisor_i,
  output logic                     busy_o,
  output logic                     done_o,
  output logic [yfd_pkg::DimW-1:0] quotient_o
);
  import yfd_pkg::*;

  logic [DimW-1:0]    rem_q, rem_d;
  logic [DimW-1:0]    dvd_q, dvd_d;
  logic [DimW-1:0]    dsr_q, dsr_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DimW:0]      shifted;
  logic [DimW:0]      trial;
  logic               fits;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    shifted = {rem_q, dvd_q[DimW-1]};
    trial   = shifted - {1'b0, dsr_q};
    fits    = shifted >= {1'b0, dsr_q};
  end

  // Step sequencing.
  always_comb begin
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      dvd_d  = dividend_i;
      dsr_d  = divisor_i;
      cnt_d  = DivCntW'(DimW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? trial[DimW-1:0] : shifted[DimW-1:0];
      dvd_d = {dvd_q[DimW-2:0], fits};
      cnt_d = cnt_q - DivCntW'(1);
      if (cnt_q == DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state is reset; the datapath is not.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

### sv/yuyv_frame_decimator.sv
// Top level of the YUYV frame decimator: register file, skip derivation,
// frame position counters and the output register.
// Depends on yfd_pkg and yfd_div.
//
// The decimator takes a YUYV frame in raster order, one 32-bit macropixel
// per beat, with tuser marking the first beat of a frame, and forwards the
// macropixels that land in the preview overlay together with their overlay
// line and macropixel column. Once the skip factors are settled it accepts
// one beat per clock while the output is not stalled, and a beat's result
// is presented in the cycle after it is accepted; the output register lets
// a new beat in while a result is still being taken. After every write to
// a dimension register the two skip factors are recomputed by a pair of
// bit-serial dividers, and the input stalls through the start, the divide
// steps and the update; writes are meant to be made between frames. After
// reset the skips hold the values for the reset dimensions; no stall occurs.
module yuyv_frame_decimator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration write port.
  input  logic                        cfg_we_i,
  input  logic [yfd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [yfd_pkg::DimW-1:0]    cfg_wdata_i,
  // Input stream.
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // tdata: [31:0] macropixel_in (Y0 U Y1 V, Y0 lowest)
  input  logic [yfd_pkg::PixW-1:0]    s_axis_tdata,
  // tuser: [0] frame_start
  input  logic                        s_axis_tuser,
  // Output stream.
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // tdata: [31:0] macropixel_out, [43:32] out_row, [54:44] out_column, [55] zero
  output logic [yfd_pkg::OutDataW-1:0] m_axis_tdata
);
  import yfd_pkg::*;

  localparam logic [DimW-1:0] MaxDimV = DimW'(MaxDim);

  // Dimension registers.
  logic [DimW-1:0] cam_w_q, cam_h_q, prev_w_q, prev_h_q;
  logic [DimW-1:0] cfg_val;
  logic            cfg_hit;

  // Skip factors and divider control.
  logic [DimW-1:0] horiz_skip_q, vert_skip_q;
  logic            start_q;
  logic            h_busy, v_busy, h_done, v_done;
  logic [DimW-1:0] h_quot, v_quot;
  logic [DimW:0]   ceil_sum;
  logic            h_mode_cfg, v_mode_cfg;
  logic            dividing;

  // Frame position state.
  logic [ColW-1:0]   in_col_q;
  logic [DimW-1:0]   in_row_q;
  logic [DimW-2:0]   row_ph_q, col_ph_q;
  logic [DimW-1:0]   dst_row_q;
  logic [DimW-2:0]   dst_col_q;

  // Output register.
  logic            out_valid_q;
  logic [PixW-1:0] out_pix_q;
  logic [RowW-1:0] out_row_q;
  logic [ColW-1:0] out_col_q;

  // Step logic.
  logic            s_accept;
  logic            fs;
  logic [ColW-1:0] in_col;
  logic [DimW-1:0] in_row;
  logic [DimW-2:0] row_ph, col_ph;
  logic [DimW-1:0] dst_row;
  logic [DimW-2:0] dst_col;
  logic [ColW:0]   line_mp, crop_mp, prev_mp;
  logic [DimW-1:0] min_w;
  logic            horiz_mode;
  logic            row_ok, col_ok, keep;
  logic [ColW-1:0] col_sel;
  logic [DimW-1:0] col_ph_inc, row_ph_inc;
  logic [ColW:0]   in_col_inc;
  logic            line_end;
  logic [ColW-1:0] in_col_nx;
  logic [DimW-1:0] in_row_nx;
  logic [DimW-2:0] row_ph_nx, col_ph_nx;
  logic [DimW-1:0] dst_row_nx;
  logic [DimW-2:0] dst_col_nx;

  // Saturate written values to the largest supported dimension.
  assign cfg_val = (cfg_wdata_i > MaxDimV) ? MaxDimV : cfg_wdata_i;
  assign cfg_hit = cfg_we_i && (cfg_index_i == RegCameraWidth ||
                                cfg_index_i == RegCameraHeight ||
                                cfg_index_i == RegPreviewWidth ||
                                cfg_index_i == RegPreviewHeight);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_w_q  <= CameraWidthReset;
      cam_h_q  <= CameraHeightReset;
      prev_w_q <= PreviewWidthReset;
      prev_h_q <= PreviewHeightReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegCameraWidth:   cam_w_q  <= cfg_val;
        RegCameraHeight:  cam_h_q  <= cfg_val;
        RegPreviewWidth:  prev_w_q <= cfg_val;
        RegPreviewHeight: prev_h_q <= cfg_val;
        default: ;
      endcase
    end
  end

  // Skip derivation: horizontal is a plain quotient, vertical a ceiling.
  assign ceil_sum   = {1'b0, cam_h_q} + {1'b0, prev_h_q} - (DimW+1)'(1);
  assign h_mode_cfg = (prev_w_q != '0) && ({prev_w_q, 1'b0} <= {1'b0, cam_w_q});
  assign v_mode_cfg = (prev_h_q != '0) && (prev_h_q < cam_h_q);

  yfd_div u_div_h (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_q),
    .dividend_i (cam_w_q),
    .divisor_i  (prev_w_q),
    .busy_o     (h_busy),
    .done_o     (h_done),
    .quotient_o (h_quot)
  );

  yfd_div u_div_v (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_q),
    .dividend_i (ceil_sum[DimW-1:0]),
    .divisor_i  (prev_h_q),
    .busy_o     (v_busy),
    .done_o     (v_done),
    .quotient_o (v_quot)
  );

  assign dividing = start_q || h_busy || v_busy || h_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q      <= 1'b0;
      horiz_skip_q <= HorizSkipReset;
      vert_skip_q  <= VertSkipReset;
    end else begin
      start_q <= cfg_hit;
      if (h_done && v_done) begin
        horiz_skip_q <= h_mode_cfg ? h_quot : '0;
        vert_skip_q  <= v_mode_cfg ? v_quot : DimW'(1);
      end
    end
  end

  // Handshake: input is held off while dividing; the output register frees up when its beat is taken.
  assign s_axis_tready = !dividing && (!out_valid_q || m_axis_tready);
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // Position as seen by this beat; a frame start clears it first.
  always_comb begin
    fs      = s_axis_tuser;
    in_col  = fs ? '0 : in_col_q;
    in_row  = fs ? '0 : in_row_q;
    row_ph  = fs ? '0 : row_ph_q;
    col_ph  = fs ? '0 : col_ph_q;
    dst_row = fs ? '0 : dst_row_q;
    dst_col = fs ? '0 : dst_col_q;
  end

  // Keep decision for this beat.
  always_comb begin
    line_mp    = (cam_w_q[DimW-1:1] == '0) ? (ColW+1)'(1) : cam_w_q[DimW-1:1];
    min_w      = (prev_w_q < cam_w_q) ? prev_w_q : cam_w_q;
    crop_mp    = min_w[DimW-1:1];
    prev_mp    = prev_w_q[DimW-1:1];
    horiz_mode = horiz_skip_q != '0;
    row_ok     = (in_row < cam_h_q) && (row_ph == '0) && (dst_row < prev_h_q);
    if (horiz_mode) begin
      col_ok  = (col_ph == '0) && (dst_col < prev_mp);
      col_sel = dst_col[ColW-1:0];
    end else begin
      col_ok  = {1'b0, in_col} < crop_mp;
      col_sel = in_col;
    end
    keep = row_ok && col_ok;
  end

  // Advance the position counters.
  always_comb begin
    col_ph_inc = {1'b0, col_ph} + DimW'(1);
    row_ph_inc = {1'b0, row_ph} + DimW'(1);
    in_col_inc = {1'b0, in_col} + (ColW+1)'(1);
    line_end   = in_col_inc >= line_mp;

    dst_col_nx = dst_col;
    col_ph_nx  = col_ph;
    if (horiz_mode) begin
      if (col_ph == '0 && {1'b0, dst_col} < MaxDimV) begin
        dst_col_nx = dst_col + (DimW-1)'(1);
      end
      col_ph_nx = (col_ph_inc >= horiz_skip_q) ? '0 : col_ph_inc[DimW-2:0];
    end

    in_col_nx  = in_col_inc[ColW-1:0];
    in_row_nx  = in_row;
    row_ph_nx  = row_ph;
    dst_row_nx = dst_row;
    if (line_end) begin
      in_col_nx  = '0;
      col_ph_nx  = '0;
      dst_col_nx = '0;
      if (in_row < cam_h_q) begin
        if (row_ph == '0 && dst_row < MaxDimV) begin
          dst_row_nx = dst_row + DimW'(1);
        end
        row_ph_nx = (row_ph_inc >= vert_skip_q) ? '0 : row_ph_inc[DimW-2:0];
        in_row_nx = in_row + DimW'(1);
      end
    end
  end

  // Position state and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q    <= '0;
      in_row_q    <= '0;
      row_ph_q    <= '0;
      col_ph_q    <= '0;
      dst_row_q   <= '0;
      dst_col_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_accept) begin
        in_col_q    <= in_col_nx;
        in_row_q    <= in_row_nx;
        row_ph_q    <= row_ph_nx;
        col_ph_q    <= col_ph_nx;
        dst_row_q   <= dst_row_nx;
        dst_col_q   <= dst_col_nx;
        out_valid_q <= keep;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      out_pix_q <= s_axis_tdata;
      out_row_q <= dst_row[RowW-1:0];
      out_col_q <= col_sel;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_col_q, out_row_q, out_pix_q};

  // No beat enters while the skip factors are being recomputed.
  a_no_accept_while_dividing: assert property (
    @(posedge clk_i) disable iff (!rst_ni) dividing |-> !s_axis_tready)
    else $error("input accepted while skips are being recomputed");

  // A held result blocks the input.
  a_stall_blocks_input: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while the output register is full");

  // A kept beat shows up at the output in the next cycle.
  a_keep_reaches_output: assert property (
    @(posedge clk_i) disable iff (!rst_ni) (s_accept && keep) |=> m_axis_tvalid)
    else $error("kept beat did not reach the output register");

  // The vertical period is never zero.
  a_vert_skip_nonzero: assert property (
    @(posedge clk_i) disable iff (!rst_ni) vert_skip_q != '0)
    else $error("vertical skip became zero");

endmodule
